>>> hw/rtl/traffic_light_buzzer_controller_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the traffic light buzzer controller
// Clocked, reset-gated property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_BUZZER_CONTROLLER_TOP_MACROS_SVH
`define TRAFFIC_LIGHT_BUZZER_CONTROLLER_TOP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TLBC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define TLBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	`TLBC_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/tlbc_pkg.sv
// ----------------------------------------------------------------------------
// tlbc_pkg
// Shared types, register map and helpers for the traffic light controller.
// ----------------------------------------------------------------------------
package tlbc_pkg;

	localparam int TIMER_BITS = 16;
	localparam int REG_W      = 16;
	localparam int CMP_W      = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [REG_W-1:0]      reg_t;

	typedef enum logic [2:0] {
		PH_RED        = 3'd0,
		PH_RED_YELLOW = 3'd1,
		PH_YELLOW     = 3'd2,
		PH_GREEN      = 3'd3,
		PH_WAIT       = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		REG_RED_LEN        = 3'd0,
		REG_RED_YELLOW_LEN = 3'd1,
		REG_YELLOW_LEN     = 3'd2,
		REG_GREEN_LEN      = 3'd3,
		REG_WAIT_LEN       = 3'd4,
		REG_GREEN_BEEP_ON  = 3'd5,
		REG_GREEN_BEEP_OFF = 3'd6,
		REG_RED_BEEP_HALF  = 3'd7
	} cfg_idx_t;

	localparam reg_t RST_RED_LEN        = 16'd10000;
	localparam reg_t RST_RED_YELLOW_LEN = 16'd2000;
	localparam reg_t RST_YELLOW_LEN     = 16'd2000;
	localparam reg_t RST_GREEN_LEN      = 16'd5000;
	localparam reg_t RST_WAIT_LEN       = 16'd5000;
	localparam reg_t RST_GREEN_BEEP_ON  = 16'd500;
	localparam reg_t RST_GREEN_BEEP_OFF = 16'd1500;
	localparam reg_t RST_RED_BEEP_HALF  = 16'd250;

	typedef struct packed {
		reg_t red_len;
		reg_t red_yellow_len;
		reg_t yellow_len;
		reg_t green_len;
		reg_t wait_len;
		reg_t green_beep_on;
		reg_t green_beep_off;
		reg_t red_beep_half;
	} cfg_t;

	// Saturating increment: hold at all ones.
	function automatic timer_t sat_inc(input timer_t v);
		timer_t r;
		r = (v == {TIMER_BITS{1'b1}}) ? v : v + timer_t'(1);
		return r;
	endfunction

	// Unsigned elapsed > length, both widened to a common width.
	function automatic logic past_len(input timer_t elapsed, input reg_t len);
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
		a = CMP_W'(elapsed);
		b = CMP_W'(len);
		return a > b;
	endfunction

endpackage

>>> hw/rtl/tlbc_ifs.sv
// ----------------------------------------------------------------------------
// tlbc channel interfaces
// Tick input, result output and register write channels.
// ----------------------------------------------------------------------------
interface tlbc_tick_if;
	logic valid;
	logic ready;
	logic button;

	modport source (output valid, output button, input ready);
	modport sink   (input valid, input button, output ready);
endinterface

interface tlbc_result_if;
	logic       valid;
	logic       ready;
	logic       red_lamp;
	logic       yellow_lamp;
	logic       green_lamp;
	logic       beep;
	logic [2:0] phase;

	modport source (output valid, output red_lamp, output yellow_lamp, output green_lamp,
		output beep, output phase, input ready);
	modport sink   (input valid, input red_lamp, input yellow_lamp, input green_lamp,
		input beep, input phase, output ready);
endinterface

interface tlbc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/tlbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tlbc_cfg_regs
// Register file for phase lengths and buzzer cadence.
// ----------------------------------------------------------------------------
module tlbc_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	tlbc_cfg_if.sink     cfg,
	output tlbc_pkg::cfg_t regs
);
	import tlbc_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.red_len        <= RST_RED_LEN;
			regs_q.red_yellow_len <= RST_RED_YELLOW_LEN;
			regs_q.yellow_len     <= RST_YELLOW_LEN;
			regs_q.green_len      <= RST_GREEN_LEN;
			regs_q.wait_len       <= RST_WAIT_LEN;
			regs_q.green_beep_on  <= RST_GREEN_BEEP_ON;
			regs_q.green_beep_off <= RST_GREEN_BEEP_OFF;
			regs_q.red_beep_half  <= RST_RED_BEEP_HALF;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_RED_LEN:        regs_q.red_len        <= cfg.data;
				REG_RED_YELLOW_LEN: regs_q.red_yellow_len <= cfg.data;
				REG_YELLOW_LEN:     regs_q.yellow_len     <= cfg.data;
				REG_GREEN_LEN:      regs_q.green_len      <= cfg.data;
				REG_WAIT_LEN:       regs_q.wait_len       <= cfg.data;
				REG_GREEN_BEEP_ON:  regs_q.green_beep_on  <= cfg.data;
				REG_GREEN_BEEP_OFF: regs_q.green_beep_off <= cfg.data;
				REG_RED_BEEP_HALF:  regs_q.red_beep_half  <= cfg.data;
				default:            regs_q <= regs_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/tlbc_light_ctrl.sv
// ----------------------------------------------------------------------------
// tlbc_light_ctrl
// Light phase sequencer with saturating elapsed counter.
// ----------------------------------------------------------------------------
module tlbc_light_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             button,
	input  tlbc_pkg::cfg_t   regs,
	output tlbc_pkg::phase_t phase_nxt
);
	import tlbc_pkg::*;

	phase_t phase_q;
	timer_t elapsed_q;
	timer_t elapsed_inc;
	timer_t elapsed_nxt;

	always_comb begin
		elapsed_inc = sat_inc(elapsed_q);
		phase_nxt   = phase_q;
		elapsed_nxt = elapsed_inc;
		unique case (phase_q)
			PH_RED_YELLOW: begin
				if (past_len(elapsed_inc, regs.red_yellow_len)) begin
					phase_nxt   = PH_GREEN;
					elapsed_nxt = '0;
				end
			end
			PH_YELLOW: begin
				if (past_len(elapsed_inc, regs.yellow_len)) begin
					phase_nxt   = PH_RED;
					elapsed_nxt = '0;
				end
			end
			PH_GREEN: begin
				if (past_len(elapsed_inc, regs.green_len) && button) begin
					phase_nxt   = PH_WAIT;
					elapsed_nxt = '0;
				end
			end
			PH_WAIT: begin
				if (past_len(elapsed_inc, regs.wait_len)) begin
					phase_nxt   = PH_YELLOW;
					elapsed_nxt = '0;
				end
			end
			default: begin
				// red, and any stray code falls back to red
				phase_nxt = PH_RED;
				if (past_len(elapsed_inc, regs.red_len)) begin
					phase_nxt   = PH_RED_YELLOW;
					elapsed_nxt = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_RED;
			elapsed_q <= '0;
		end else if (adv) begin
			phase_q   <= phase_nxt;
			elapsed_q <= elapsed_nxt;
		end
	end

endmodule

>>> hw/rtl/tlbc_beep_ctrl.sv
// ----------------------------------------------------------------------------
// tlbc_beep_ctrl
// Buzzer on/off cadence following the updated light phase.
// ----------------------------------------------------------------------------
module tlbc_beep_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  tlbc_pkg::phase_t phase_nxt,
	input  tlbc_pkg::cfg_t   regs,
	output logic             beep_nxt
);
	import tlbc_pkg::*;

	logic   active_q;
	logic   red_cad_q;
	timer_t elapsed_q;
	timer_t elapsed_inc;
	timer_t elapsed_nxt;
	logic   red_cad_nxt;
	logic   green_like;
	reg_t   limit;

	always_comb begin
		elapsed_inc = sat_inc(elapsed_q);
		green_like  = (phase_nxt == PH_GREEN) || (phase_nxt == PH_WAIT);
		limit       = red_cad_q ? regs.red_beep_half
			: (active_q ? regs.green_beep_on : regs.green_beep_off);
		beep_nxt    = active_q;
		red_cad_nxt = red_cad_q;
		elapsed_nxt = elapsed_inc;
		if ((phase_nxt == PH_YELLOW) || (phase_nxt == PH_RED_YELLOW)) begin
			// silent, restart on red cadence
			beep_nxt    = 1'b0;
			red_cad_nxt = 1'b1;
			elapsed_nxt = '0;
		end else if (past_len(elapsed_inc, limit)) begin
			beep_nxt    = !active_q;
			red_cad_nxt = !green_like;
			elapsed_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			red_cad_q <= 1'b1;
			elapsed_q <= '0;
		end else if (adv) begin
			active_q  <= beep_nxt;
			red_cad_q <= red_cad_nxt;
			elapsed_q <= elapsed_nxt;
		end
	end

endmodule

>>> hw/rtl/traffic_light_buzzer_controller_top.sv
// ----------------------------------------------------------------------------
// traffic_light_buzzer_controller_top: pedestrian light with buzzer
// A tick passes an input register, then a result register; one tick per cycle
// sustained unless the result side stalls, set by the light and buzzer update loop.
// Reset clears phase to red, counters to zero and registers to defaults.
// ----------------------------------------------------------------------------
module traffic_light_buzzer_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	tlbc_tick_if.sink   tick,
	tlbc_result_if.source result,
	tlbc_cfg_if.sink    cfg
);
	import tlbc_pkg::*;

	// Stage 1: captured tick. Stage 2: result word waiting for the sink.
	logic   valid_s1;
	logic   button_s1;
	logic   valid_s2;
	phase_t phase_s2;
	logic   beep_s2;

	logic   s2_free;
	logic   adv;
	cfg_t   regs;
	phase_t phase_nxt;
	logic   beep_nxt;

	// The result register frees up when empty or when its word is taken this
	// cycle; the input register then drains into it, so a new tick can enter
	// in the same cycle while a finished word still sits at the output.
	assign s2_free    = !valid_s2 || result.ready;
	assign adv        = valid_s1 && s2_free;
	assign tick.ready = !valid_s1 || s2_free;

	// Register file; write it only between ticks (the block does not enforce this).
	tlbc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Light sequencer: advance its state once per tick moved into stage 2.
	tlbc_light_ctrl u_light (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.button    (button_s1),
		.regs      (regs),
		.phase_nxt (phase_nxt)
	);

	// Buzzer sees the phase after this tick's light update.
	tlbc_beep_ctrl u_beep (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.phase_nxt (phase_nxt),
		.regs      (regs),
		.beep_nxt  (beep_nxt)
	);

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload: hold the button until it moves on; load the result on advance.
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			button_s1 <= tick.button;
		end
		if (adv) begin
			phase_s2 <= phase_nxt;
			beep_s2  <= beep_nxt;
		end
	end

	// Drive the lamps straight from the registered phase.
	assign result.valid       = valid_s2;
	assign result.phase       = phase_s2;
	assign result.beep        = beep_s2;
	assign result.red_lamp    = (phase_s2 == PH_RED) || (phase_s2 == PH_RED_YELLOW);
	assign result.yellow_lamp = (phase_s2 == PH_RED_YELLOW) || (phase_s2 == PH_YELLOW);
	assign result.green_lamp  = (phase_s2 == PH_GREEN) || (phase_s2 == PH_WAIT);

endmodule

>>> hw/rtl/tlbc_checker.sv
// ----------------------------------------------------------------------------
// tlbc_checker
// Port-level checks on the controller's result channel, bound to the top.
// ----------------------------------------------------------------------------
`include "traffic_light_buzzer_controller_top_macros.svh"

module tlbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       red_lamp,
	input logic       yellow_lamp,
	input logic       green_lamp,
	input logic       beep,
	input logic [2:0] phase
);
	import tlbc_pkg::*;

	logic stall;
	logic yellow_ph;
	logic red_ph;

	assign stall     = out_valid && !out_ready;
	assign yellow_ph = (phase == PH_YELLOW) || (phase == PH_RED_YELLOW);
	assign red_ph    = (phase == PH_RED) || (phase == PH_RED_YELLOW);

	`TLBC_ASSERT(a_stall_hold, clk, arst_n, stall |=> (out_valid && $stable(phase) && $stable(beep)), "stalled result changed")
	`TLBC_ASSERT_IMPLY(a_lamp_map, clk, arst_n, out_valid, (red_lamp == red_ph) && (green_lamp == ((phase == PH_GREEN) || (phase == PH_WAIT))) && (yellow_lamp == yellow_ph), "lamps disagree with phase")
	`TLBC_ASSERT_IMPLY(a_quiet_yellow, clk, arst_n, out_valid && yellow_ph, !beep, "buzzer sounding in a yellow phase")
	`TLBC_ASSERT_IMPLY(a_phase_legal, clk, arst_n, out_valid, phase <= PH_WAIT, "phase code out of range")

endmodule

bind traffic_light_buzzer_controller_top tlbc_checker u_tlbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.red_lamp    (result.red_lamp),
	.yellow_lamp (result.yellow_lamp),
	.green_lamp  (result.green_lamp),
	.beep        (result.beep),
	.phase       (result.phase)
);

>>> verif/tlbc_lamp_checker.sv
// ----------------------------------------------------------------------------
// tlbc_lamp_checker
// Watches the tick, result and register channels of the traffic light buzzer
// controller. Steps its own light and buzzer model on every accepted tick and
// compares every accepted result word with the oldest predicted word.
// ----------------------------------------------------------------------------
module tlbc_lamp_checker (
	input  logic   clk,
	input  logic   arst_n,
	tlbc_tick_if   tick,
	tlbc_result_if result,
	tlbc_cfg_if    cfg,
	output int     pending,
	output int     errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import tlbc_pkg::*;

	localparam int NUM_REGS  = 8;

	typedef struct packed {
		logic   red;
		logic   yellow;
		logic   green;
		logic   beep;
		phase_t phase;
	} lamp_word_t;

	reg_t       regs_q [NUM_REGS];
	phase_t     light_ph;
	timer_t     light_cnt;
	logic       buzz_on;
	logic       buzz_red;
	timer_t     buzz_cnt;
	lamp_word_t lamps_due [$];

	// Count up, hold at all ones.
	function automatic timer_t bump(input timer_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void enter_phase(input phase_t p);
		light_ph  = p;
		light_cnt = '0;
	endfunction

	// Light first, then the buzzer, which sees the new phase.
	function automatic void advance_tick(input logic button);
		reg_t limit;
		logic green_like;
		light_cnt = bump(light_cnt);
		case (light_ph)
			PH_RED_YELLOW: if (light_cnt > regs_q[REG_RED_YELLOW_LEN]) enter_phase(PH_GREEN);
			PH_YELLOW:     if (light_cnt > regs_q[REG_YELLOW_LEN]) enter_phase(PH_RED);
			PH_GREEN:      if (light_cnt > regs_q[REG_GREEN_LEN] && button) enter_phase(PH_WAIT);
			PH_WAIT:       if (light_cnt > regs_q[REG_WAIT_LEN]) enter_phase(PH_YELLOW);
			default: begin
				light_ph = PH_RED;
				if (light_cnt > regs_q[REG_RED_LEN]) enter_phase(PH_RED_YELLOW);
			end
		endcase

		green_like = (light_ph == PH_GREEN) || (light_ph == PH_WAIT);
		buzz_cnt   = bump(buzz_cnt);
		if (light_ph == PH_YELLOW || light_ph == PH_RED_YELLOW) begin
			buzz_on  = 1'b0;
			buzz_red = 1'b1;
			buzz_cnt = '0;
		end else begin
			if (buzz_red)
				limit = regs_q[REG_RED_BEEP_HALF];
			else
				limit = buzz_on ? regs_q[REG_GREEN_BEEP_ON] : regs_q[REG_GREEN_BEEP_OFF];
			if (buzz_cnt > limit) begin
				buzz_on  = !buzz_on;
				buzz_red = !green_like;
				buzz_cnt = '0;
			end
		end
	endfunction

	function automatic lamp_word_t lamps_now();
		lamp_word_t w;
		w.red    = (light_ph == PH_RED) || (light_ph == PH_RED_YELLOW);
		w.yellow = (light_ph == PH_RED_YELLOW) || (light_ph == PH_YELLOW);
		w.green  = (light_ph == PH_GREEN) || (light_ph == PH_WAIT);
		w.beep   = buzz_on;
		w.phase  = light_ph;
		return w;
	endfunction

	// Print one line per mismatch and count it.
	task automatic report(input string msg);
		errors++;
		$display("[%0t] lamp check: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
		if (got !== want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		lamp_word_t due;
		if (!arst_n) begin
			regs_q[REG_RED_LEN]        = RST_RED_LEN;
			regs_q[REG_RED_YELLOW_LEN] = RST_RED_YELLOW_LEN;
			regs_q[REG_YELLOW_LEN]     = RST_YELLOW_LEN;
			regs_q[REG_GREEN_LEN]      = RST_GREEN_LEN;
			regs_q[REG_WAIT_LEN]       = RST_WAIT_LEN;
			regs_q[REG_GREEN_BEEP_ON]  = RST_GREEN_BEEP_ON;
			regs_q[REG_GREEN_BEEP_OFF] = RST_GREEN_BEEP_OFF;
			regs_q[REG_RED_BEEP_HALF]  = RST_RED_BEEP_HALF;
			light_ph  = PH_RED;
			light_cnt = '0;
			buzz_on   = 1'b0;
			buzz_red  = 1'b1;
			buzz_cnt  = '0;
			lamps_due.delete();
			errors    = 0;
			pending  <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				regs_q[cfg.index] = cfg.data;
			// Match results before queueing this edge's tick, so a stray word
			// cannot pair with a tick that was only just taken.
			if (result.valid && result.ready) begin
				if (lamps_due.size() == 0) begin
					report("result word with no tick outstanding");
				end else begin
					due = lamps_due.pop_front();
					check_field("red_lamp", result.red_lamp, due.red);
					check_field("yellow_lamp", result.yellow_lamp, due.yellow);
					check_field("green_lamp", result.green_lamp, due.green);
					check_field("beep", result.beep, due.beep);
					check_field("phase", result.phase, due.phase);
				end
			end
			if (tick.valid && tick.ready) begin
				advance_tick(tick.button);
				lamps_due.push_back(lamps_now());
			end
			pending <= lamps_due.size();
		end
	end

endmodule

>>> verif/traffic_light_buzzer_controller_top_tb.sv
// ----------------------------------------------------------------------------
// traffic_light_buzzer_controller_top_tb
// Drives button ticks and register writes into the pedestrian light, stalls
// the result side at random, and leaves prediction and comparison to the lamp
// checker. Covers short directed walks through every phase and randomized
// register settings, with one stretch that runs with no idling.
// ----------------------------------------------------------------------------
module traffic_light_buzzer_controller_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlbc_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int NUM_REGS      = 8;
	localparam int IDLE_PCT      = 9;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 6;
	localparam int RANDOM_PHASES = 11;
	localparam int STEADY_PHASE  = 4;

	localparam reg_t REG_MAX     = '1;

	// Button levels for the directed walks, bit 0 goes first.
	localparam logic [11:0] WALK_ZERO_BUTTONS  = 12'b1110_0011_0000;
	localparam logic [12:0] WALK_SHORT_BUTTONS = 13'b1_1110_1111_1111;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int   pending;
	int   errors;
	int   quiet_cycles;
	reg_t plan [NUM_REGS];

	tlbc_tick_if   tick_ch ();
	tlbc_result_if result_ch ();
	tlbc_cfg_if    cfg_ch ();

	traffic_light_buzzer_controller_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	tlbc_lamp_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.pending (pending),
		.errors  (errors)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Drop ready at random unless a steady stretch is running.
	always @(posedge clk)
		result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

	// Count cycles with no word moving on any channel; give up at the limit.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Write every register from the plan, back to back.
	task automatic load_plan();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= cfg_idx_t'(i);
			cfg_ch.data  <= plan[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Offer one tick word, with random idle cycles ahead of it; hold valid
	// high afterwards so the next word can follow without a bubble.
	task automatic send_word(input logic button);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid  <= 1'b1;
		tick_ch.button <= button;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	// Drop valid, wait out every outstanding result, then let the pipeline
	// settle before any register is touched.
	task automatic drain();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly short lengths so phases turn over often; now and then zero or
	// the largest value, and the largest value parks the light or buzzer in place.
	task automatic roll_plan();
		int pick;
		for (int i = 0; i < NUM_REGS; i++) begin
			pick = $urandom_range(99);
			if (pick < 8)
				plan[i] = '0;
			else if (pick < 12)
				plan[i] = REG_MAX;
			else if (pick < 30)
				plan[i] = reg_t'($urandom_range(40));
			else
				plan[i] = reg_t'($urandom_range(6));
		end
	endtask

	initial begin
		int press;
		int n;

		arst_n          = 1'b0;
		steady          = 1'b0;
		tick_ch.valid   = 1'b0;
		tick_ch.button  = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_RED_LEN;
		cfg_ch.data     = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All lengths zero: every phase lasts one tick, green waits for the
		// button, the buzzer flips on every tick outside the yellow phases.
		foreach (plan[i]) plan[i] = '0;
		load_plan();
		for (int k = 0; k < 12; k++) send_word(WALK_ZERO_BUTTONS[k]);
		drain();

		// Short distinct lengths, with the button let go once in green.
		plan[REG_RED_LEN]        = 16'd2;
		plan[REG_RED_YELLOW_LEN] = 16'd1;
		plan[REG_YELLOW_LEN]     = 16'd1;
		plan[REG_GREEN_LEN]      = 16'd3;
		plan[REG_WAIT_LEN]       = 16'd2;
		plan[REG_GREEN_BEEP_ON]  = 16'd1;
		plan[REG_GREEN_BEEP_OFF] = 16'd2;
		plan[REG_RED_BEEP_HALF]  = 16'd1;
		load_plan();
		for (int k = 0; k < 13; k++) send_word(WALK_SHORT_BUTTONS[k]);
		drain();

		for (int r = 0; r < RANDOM_PHASES; r++) begin
			// One phase runs with no idling on either side.
			steady <= (r == STEADY_PHASE);
			roll_plan();
			load_plan();
			case ($urandom_range(2))
				0:       press = 10;
				1:       press = 50;
				default: press = 90;
			endcase
			n = $urandom_range(35, 65);
			for (int k = 0; k < n; k++) send_word($urandom_range(99) < press);
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
